// File: sv/assert_macros.svh
// assertion helpers shared by the rtl files
// they expect signals named clk and rst_n in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock outside reset
`define TTV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every clock outside reset
`define TTV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: sv/ttv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttv_pkg
// shared types and constants of the triangle tangent vector block
// ----------------------------------------------------------------------------
package ttv_pkg;

    localparam int IDX_W         = 24;
    localparam int COORD_W       = 32;
    localparam int DIFF_W        = COORD_W + 1;
    localparam int PROD_W        = 2 * DIFF_W;
    localparam int ACC_W         = PROD_W + 1;
    localparam int MAG_W         = PROD_W;
    localparam int NORM_W        = 30;
    localparam int TAN_W         = 16;
    localparam int OUT_FRAC_BITS = 14;
    localparam int QUO_W         = OUT_FRAC_BITS + 2;
    localparam int NUM_W         = NORM_W + OUT_FRAC_BITS + 1;
    localparam int REM_W         = 33;
    localparam int IN_DATA_W     = IDX_W + 5 * COORD_W;
    localparam int OUT_DATA_W    = 72;
    localparam int FIFO_DEPTH    = 2;

    // one triangle handed from the front to the back
    typedef struct packed {
        logic [2:0][IDX_W-1:0]  idx;
        logic [2:0][DIFF_W-1:0] e1;
        logic [2:0][DIFF_W-1:0] e2;
        logic [DIFF_W-1:0]      d1u;
        logic [DIFF_W-1:0]      d1v;
        logic [DIFF_W-1:0]      d2u;
        logic [DIFF_W-1:0]      d2v;
    } ttv_job_t;

endpackage
`default_nettype wire

// File: sv/ttv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ttv_front
// accepts corners, holds two, builds edges and uv deltas on the third
// ----------------------------------------------------------------------------
module ttv_front
    import ttv_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic                 q_full,
    output logic                      q_push,
    output ttv_job_t                  q_job
);

    logic [1:0]         count_reg;
    logic [IDX_W-1:0]   hidx_reg [2];
    logic [COORD_W-1:0] hpos_reg [6];
    logic [COORD_W-1:0] htex_reg [4];
    logic [COORD_W-1:0] cpos [3];
    logic [COORD_W-1:0] ctex [2];
    logic               accept;

    // field split of the incoming corner
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cpos[i] = s_tdata[IDX_W + i*COORD_W +: COORD_W];
        end
        for (int i = 0; i < 2; i++)
        begin
            ctex[i] = s_tdata[IDX_W + (3+i)*COORD_W +: COORD_W];
        end
    end

    assign s_tready = (count_reg != 2'd2) || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign q_push   = accept && (count_reg == 2'd2);

    // edges and deltas, sign extended by one bit
    always_comb
    begin
        q_job.idx[0] = hidx_reg[0];
        q_job.idx[1] = hidx_reg[1];
        q_job.idx[2] = s_tdata[IDX_W-1:0];
        for (int i = 0; i < 3; i++)
        begin
            q_job.e1[i] = {hpos_reg[3+i][COORD_W-1], hpos_reg[3+i]}
                        - {hpos_reg[i][COORD_W-1], hpos_reg[i]};
            q_job.e2[i] = {cpos[i][COORD_W-1], cpos[i]}
                        - {hpos_reg[i][COORD_W-1], hpos_reg[i]};
        end
        q_job.d1u = {htex_reg[2][COORD_W-1], htex_reg[2]} - {htex_reg[0][COORD_W-1], htex_reg[0]};
        q_job.d1v = {htex_reg[3][COORD_W-1], htex_reg[3]} - {htex_reg[1][COORD_W-1], htex_reg[1]};
        q_job.d2u = {ctex[0][COORD_W-1], ctex[0]} - {htex_reg[0][COORD_W-1], htex_reg[0]};
        q_job.d2v = {ctex[1][COORD_W-1], ctex[1]} - {htex_reg[1][COORD_W-1], htex_reg[1]};
    end

    // corner counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (accept)
        begin
            count_reg <= (count_reg == 2'd2) ? 2'd0 : count_reg + 2'd1;
        end
    end

    // held corners
    always_ff @(posedge clk)
    begin
        if (accept && (count_reg != 2'd2))
        begin
            hidx_reg[count_reg[0]] <= s_tdata[IDX_W-1:0];
            for (int i = 0; i < 3; i++)
            begin
                hpos_reg[3*count_reg[0] + i] <= cpos[i];
            end
            for (int i = 0; i < 2; i++)
            begin
                htex_reg[2*count_reg[0] + i] <= ctex[i];
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/ttv_fifo.sv
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ttv_fifo
// short job queue between the front and the back
// ----------------------------------------------------------------------------
module ttv_fifo
    import ttv_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  ttv_job_t      push_job,
    output logic          full,
    input  wire logic     pop,
    output logic          empty,
    output ttv_job_t      head
);

    ttv_job_t   mem_reg [FIFO_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'(FIFO_DEPTH));
    assign empty = (count_reg == 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `TTV_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
    `TTV_ASSERT_IMP(a_no_pop_empty, pop, !empty, "pop from empty queue")

endmodule
`default_nettype wire

// File: sv/ttv_back.sv
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ttv_back
// tangent sequencer: shared multiplier, normalize, square root, divide
// ----------------------------------------------------------------------------
module ttv_back
    import ttv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_empty,
    input  ttv_job_t                   q_head,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,
    output logic                       m_tuser,
    output logic                       m_tlast
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_SQ   = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam logic [QUO_W-1:0] LIM = QUO_W'(1) << OUT_FRAC_BITS;

    logic [2:0]              state_reg;
    ttv_job_t                job_reg;
    logic [3:0]              step_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg [4];
    logic [MAG_W-1:0]        mag_reg [3];
    logic [2:0]              neg_reg;
    logic                    degen_reg;
    logic [63:0]             sq_reg;
    logic [63:0]             x_reg;
    logic [63:0]             root_reg;
    logic [63:0]             bit_reg;
    logic [1:0]              comp_reg;
    logic [4:0]              dcnt_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic [15:0]             numlo_reg;
    logic [TAN_W-1:0]        tan_reg [3];
    logic [1:0]              beat_reg;
    logic                    vld_reg;
    logic [OUT_DATA_W-1:0]   data_reg;
    logic                    user_reg;
    logic                    last_reg;

    logic signed [DIFF_W-1:0] mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic [1:0]               acc_sel;
    logic [MAG_W-1:0]         mag_or;
    logic [63:0]              sqrt_sum;
    logic [NUM_W-1:0]         div_num;
    logic [REM_W-1:0]         div_trial;
    logic [REM_W-1:0]         len_ext;
    logic [QUO_W-1:0]         q_sat;
    logic signed [ACC_W-1:0]  tval [3];
    logic                     load_out;

    // multiplier operand select by step
    always_comb
    begin
        case (step_reg[2:0])
            3'd0:    begin mul_a = $signed(job_reg.d1u); mul_b = $signed(job_reg.d2v);   end
            3'd1:    begin mul_a = $signed(job_reg.d2u); mul_b = $signed(job_reg.d1v);   end
            3'd2:    begin mul_a = $signed(job_reg.d2v); mul_b = $signed(job_reg.e1[0]); end
            3'd3:    begin mul_a = $signed(job_reg.d1v); mul_b = $signed(job_reg.e2[0]); end
            3'd4:    begin mul_a = $signed(job_reg.d2v); mul_b = $signed(job_reg.e1[1]); end
            3'd5:    begin mul_a = $signed(job_reg.d1v); mul_b = $signed(job_reg.e2[1]); end
            3'd6:    begin mul_a = $signed(job_reg.d2v); mul_b = $signed(job_reg.e1[2]); end
            default: begin mul_a = $signed(job_reg.d1v); mul_b = $signed(job_reg.e2[2]); end
        endcase
    end

    // tangent components from the accumulators, without the determinant sign
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            tval[i] = acc_reg[i+1];
        end
    end

    // accumulator fed by the product of the previous step
    assign acc_sel  = 2'((step_reg - 4'd1) >> 1);
    assign mag_or   = mag_reg[0] | mag_reg[1] | mag_reg[2];
    assign sqrt_sum = root_reg + bit_reg;
    assign len_ext  = REM_W'(root_reg[31:0]);
    assign div_num  = {mag_reg[comp_reg][NORM_W-1:0], OUT_FRAC_BITS'(0)}
                    + NUM_W'(root_reg[31:1]);
    assign div_trial = {rem_reg[REM_W-2:0], numlo_reg[15]};
    assign q_sat    = (quo_reg > LIM) ? LIM : quo_reg;
    assign load_out = !vld_reg || m_tready;
    assign q_pop    = (state_reg == S_IDLE) && !q_empty;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 4'd0;
            comp_reg  <= 2'd0;
            dcnt_reg  <= 5'd0;
            beat_reg  <= 2'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (!q_empty)
                    begin
                        state_reg <= S_MUL;
                        step_reg  <= 4'd0;
                    end
                end
                S_MUL:
                begin
                    if (step_reg == 4'd8)
                    begin
                        state_reg <= S_SIGN;
                    end
                    step_reg <= step_reg + 4'd1;
                end
                S_SIGN:
                begin
                    if ((acc_reg[0] == '0) || ((tval[0] == '0) && (tval[1] == '0)
                        && (tval[2] == '0)))
                    begin
                        state_reg <= S_OUT;
                        beat_reg  <= 2'd0;
                    end
                    else
                    begin
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    if ((mag_or[MAG_W-1:NORM_W] == '0) && mag_or[NORM_W-1])
                    begin
                        state_reg <= S_SQ;
                        step_reg  <= 4'd0;
                    end
                end
                S_SQ:
                begin
                    if (step_reg == 4'd3)
                    begin
                        state_reg <= S_SQRT;
                    end
                    step_reg <= step_reg + 4'd1;
                end
                S_SQRT:
                begin
                    if (bit_reg == 64'd1)
                    begin
                        state_reg <= S_DIV;
                        comp_reg  <= 2'd0;
                        dcnt_reg  <= 5'd0;
                    end
                end
                S_DIV:
                begin
                    if (dcnt_reg == 5'(QUO_W + 1))
                    begin
                        dcnt_reg <= 5'd0;
                        if (comp_reg == 2'd2)
                        begin
                            state_reg <= S_OUT;
                            beat_reg  <= 2'd0;
                        end
                        else
                        begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        dcnt_reg <= dcnt_reg + 5'd1;
                    end
                end
                S_OUT:
                begin
                    if (load_out)
                    begin
                        if (beat_reg == 2'd3)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            beat_reg <= beat_reg + 2'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result valid, held until the receiver takes the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (load_out)
        begin
            vld_reg <= (state_reg == S_OUT) && (beat_reg != 2'd3);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                job_reg <= q_head;
            end
            S_MUL:
            begin
                prod_reg <= mul_a * mul_b;
                if (step_reg != 4'd0)
                begin
                    if (!step_reg[0])
                    begin
                        acc_reg[acc_sel] <= acc_reg[acc_sel] - ACC_W'(prod_reg);
                    end
                    else
                    begin
                        acc_reg[acc_sel] <= ACC_W'(prod_reg);
                    end
                end
            end
            S_SIGN:
            begin
                degen_reg <= (acc_reg[0] == '0) || ((tval[0] == '0) && (tval[1] == '0)
                             && (tval[2] == '0));
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= tval[i][ACC_W-1] ^ acc_reg[0][ACC_W-1];
                    mag_reg[i] <= tval[i][ACC_W-1] ? MAG_W'(-tval[i]) : MAG_W'(tval[i]);
                    tan_reg[i] <= '0;
                end
                sq_reg <= 64'd0;
            end
            S_NORM:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mag_or[MAG_W-1:NORM_W] != '0)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (!mag_or[NORM_W-1])
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
            end
            S_SQ:
            begin
                // square of one component, registered and then added to the sum
                if (step_reg != 4'd3)
                begin
                    prod_reg <= PROD_W'(mag_reg[step_reg[1:0]][NORM_W-1:0]
                                * mag_reg[step_reg[1:0]][NORM_W-1:0]);
                end
                if (step_reg != 4'd0)
                begin
                    sq_reg <= sq_reg + prod_reg[63:0];
                end
                x_reg    <= sq_reg + prod_reg[63:0];
                root_reg <= 64'd0;
                bit_reg  <= 64'd1 << 62;
            end
            S_SQRT:
            begin
                if (x_reg >= sqrt_sum)
                begin
                    x_reg    <= x_reg - sqrt_sum;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_DIV:
            begin
                if (dcnt_reg == 5'd0)
                begin
                    rem_reg   <= REM_W'(div_num[NUM_W-1:16]);
                    numlo_reg <= div_num[15:0];
                    quo_reg   <= '0;
                end
                else if (dcnt_reg <= 5'(QUO_W))
                begin
                    if (div_trial >= len_ext)
                    begin
                        rem_reg <= div_trial - len_ext;
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= div_trial;
                        quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                    end
                    numlo_reg <= numlo_reg << 1;
                end
                else
                begin
                    tan_reg[comp_reg] <= neg_reg[comp_reg] ? TAN_W'(-q_sat) : TAN_W'(q_sat);
                end
            end
            S_OUT:
            begin
                if (load_out && (beat_reg != 2'd3))
                begin
                    data_reg <= {tan_reg[2], tan_reg[1], tan_reg[0], job_reg.idx[beat_reg]};
                    user_reg <= degen_reg;
                    last_reg <= (beat_reg == 2'd2);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

    `TTV_ASSERT_IMP(a_vld_in_out, vld_reg, state_reg == S_OUT, "result outside output phase")
    `TTV_ASSERT_IMP(a_last_third, vld_reg && last_reg, beat_reg == 2'd3,
        "last flag not on third result")
    `TTV_ASSERT_IMP(a_degen_zero, vld_reg && user_reg, data_reg[OUT_DATA_W-1:IDX_W] == '0,
        "degenerate result with nonzero tangent")

endmodule
`default_nettype wire

// File: sv/triangle_tangent_vector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_tangent_vector
// per-triangle unit tangent from corner positions and texture coordinates
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one corner per transfer: index, position xyz, uv in Q16.16.
//   every third corner closes a triangle; the first two are held.
//   m_* gives three results per triangle, one per corner in arrival order,
//   with the unit tangent in Q1.14; tuser flags a degenerate triangle
//   (zero uv determinant or zero tangent, tangent then zero), tlast marks
//   the third result.
//   the back sequencer takes each job through the multiply steps, the
//   sign check, normalize shifts with a check, the component squares,
//   the square root, one divide per component and the output load; a
//   degenerate triangle goes from the sign check to the output. the
//   sequencer runs one triangle at a time and sets the sustained rate.
//   a two-entry job queue lets corners of the next triangles be taken
//   while the back part works.
//   reset clears the corner count, the queue and the output stage.
//   when the receiver stalls, the result holds and the sequencer waits;
//   corners keep flowing until the queue fills.
// ----------------------------------------------------------------------------
module triangle_tangent_vector
    import ttv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // vertex_index, pos_x, pos_y, pos_z, tex_u, tex_v
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_index, tangent_x, tangent_y, tangent_z
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // degenerate
    output logic                       m_tuser,
    output logic                       m_tlast
);

    ttv_job_t push_job;
    ttv_job_t head_job;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;

    // corner intake
    ttv_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (full),
        .q_push   (push),
        .q_job    (push_job)
    );

    // job queue
    ttv_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head_job)
    );

    // tangent computation and result stage
    ttv_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (empty),
        .q_head   (head_job),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire

// File: tb/triangle_tangent_vector_tb.sv
// ----------------------------------------------------------------------------
// triangle_tangent_vector_tb
// self-checking bench for the triangle tangent vector block
// ----------------------------------------------------------------------------
// corners go in over the s_* stream in random bursts, with extreme, degenerate
// and random triangles. A bit-exact predictor in the bench keeps its own copy
// of the held corners and queues three expected results for each triangle.
// The m_* side stalls on its own pattern, and once for a long stretch so that
// the job queue fills. Each result is checked field by field in order.
// ----------------------------------------------------------------------------
module triangle_tangent_vector_tb;
    import ttv_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RANDOM_CORNERS = 138;

    typedef struct {
        logic [IDX_W-1:0] idx;
        logic [TAN_W-1:0] tx;
        logic [TAN_W-1:0] ty;
        logic [TAN_W-1:0] tz;
        logic             degen;
        logic             last;
    } tangent_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    tangent_result_t expected_tangents[$];

    // predictor copy of the held corners
    logic [IDX_W-1:0] held_idx[2];
    longint           held_pos[6];
    longint           held_tex[4];
    int               held_count;

    int error_count;
    int corners_sent;
    int triangles_sent;
    int results_seen;
    int degenerate_seen;
    int idle_cycles;
    int hold_cycles;
    int burst_left;
    bit no_gaps;

    triangle_tangent_vector i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // integer square root, floor
    function automatic longint unsigned isqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        begin
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > x)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (x >= res + bitv)
                begin
                    x = x - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        end
    endfunction

    // tangent of one closed triangle, queued once per corner
    task automatic predict_tangent(input logic [IDX_W-1:0] idx,
                                   input logic [COORD_W-1:0] px, py, pz, u, v);
        logic signed [127:0] e1[3];
        logic signed [127:0] e2[3];
        logic signed [127:0] d1u, d1v, d2u, d2v, det, tw;
        logic [127:0]        mag[3];
        logic                neg[3];
        longint              p3[3];
        longint unsigned     m[3];
        longint unsigned     sumsq, len, q;
        logic [TAN_W-1:0]    res[3];
        logic                degen;
        int                  maxlen, k, i;
        tangent_result_t     r;
        begin
            p3[0] = longint'(signed'(px));
            p3[1] = longint'(signed'(py));
            p3[2] = longint'(signed'(pz));
            for (i = 0; i < 3; i++)
            begin
                e1[i] = held_pos[3 + i] - held_pos[i];
                e2[i] = p3[i] - held_pos[i];
            end
            d1u = held_tex[2] - held_tex[0];
            d1v = held_tex[3] - held_tex[1];
            d2u = longint'(signed'(u)) - held_tex[0];
            d2v = longint'(signed'(v)) - held_tex[1];
            det = d1u * d2v - d2u * d1v;
            degen = (det == 0);
            maxlen = 0;
            for (i = 0; i < 3; i++)
            begin
                tw = d2v * e1[i] - d1v * e2[i];
                mag[i] = (tw < 0) ? -tw : tw;
                neg[i] = (tw != 0) && ((tw < 0) ^ (det < 0));
                for (k = 127; k >= 0; k--)
                    if (mag[i][k])
                    begin
                        if (k + 1 > maxlen)
                            maxlen = k + 1;
                        break;
                    end
            end
            if (maxlen == 0)
                degen = 1'b1;
            for (i = 0; i < 3; i++)
                res[i] = '0;
            if (!degen)
            begin
                sumsq = 0;
                for (i = 0; i < 3; i++)
                begin
                    if (maxlen > NORM_W)
                        m[i] = 64'(mag[i] >> (maxlen - NORM_W));
                    else
                        m[i] = 64'(mag[i] << (NORM_W - maxlen));
                    sumsq += m[i] * m[i];
                end
                len = isqrt(sumsq);
                for (i = 0; i < 3; i++)
                begin
                    q = ((m[i] << OUT_FRAC_BITS) + len / 2) / len;
                    if (q > (64'd1 << OUT_FRAC_BITS))
                        q = 64'd1 << OUT_FRAC_BITS;
                    res[i] = neg[i] ? TAN_W'(-q) : TAN_W'(q);
                end
            end
            for (k = 0; k < 3; k++)
            begin
                r.idx = (k == 2) ? idx : held_idx[k];
                r.tx = res[0];
                r.ty = res[1];
                r.tz = res[2];
                r.degen = degen;
                r.last = (k == 2);
                expected_tangents.push_back(r);
            end
        end
    endtask

    // hold the first two corners, close the triangle on the third
    task automatic track_corner(input logic [IN_DATA_W-1:0] data);
        logic [COORD_W-1:0] f[5];
        int i;
        begin
            for (i = 0; i < 5; i++)
                f[i] = data[IDX_W + i*COORD_W +: COORD_W];
            if (held_count < 2)
            begin
                held_idx[held_count] = data[IDX_W-1:0];
                for (i = 0; i < 3; i++)
                    held_pos[held_count*3 + i] = longint'(signed'(f[i]));
                for (i = 0; i < 2; i++)
                    held_tex[held_count*2 + i] = longint'(signed'(f[3 + i]));
                held_count++;
            end
            else
            begin
                held_count = 0;
                triangles_sent++;
                predict_tangent(data[IDX_W-1:0], f[0], f[1], f[2], f[3], f[4]);
            end
        end
    endtask

    // one corner transfer, with burst gaps in front
    task automatic send_corner(input logic [IDX_W-1:0] idx,
                               input logic [COORD_W-1:0] px, py, pz, u, v);
        int gap;
        begin
            if (burst_left == 0 && !no_gaps)
            begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
            if (burst_left > 0)
                burst_left--;
            @(negedge clk);
            s_tvalid <= 1'b1;
            s_tdata  <= {v, u, pz, py, px, idx};
            do
                @(posedge clk);
            while (!s_tready);
            corners_sent++;
            track_corner({v, u, pz, py, px, idx});
        end
    endtask

    task automatic send_triangle(input logic [COORD_W-1:0] c[3][5]);
        int k;
        begin
            for (k = 0; k < 3; k++)
                send_corner(IDX_W'($urandom), c[k][0], c[k][1], c[k][2], c[k][3],
                            c[k][4]);
        end
    endtask

    // extremes of positions and texture coordinates
    task automatic test_extremes();
        logic [COORD_W-1:0] c[3][5];
        int k, f;
        begin
            for (k = 0; k < 3; k++)
                for (f = 0; f < 5; f++)
                    c[k][f] = (k == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
            c[1][4] = 32'h8000_0000;
            c[2][3] = 32'h8000_0000;
            send_triangle(c);
            for (k = 0; k < 3; k++)
                for (f = 0; f < 5; f++)
                    c[k][f] = (k == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            c[2][4] = 32'h8000_0000;
            send_triangle(c);
            // index extremes on a unit triangle
            send_corner('0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
            send_corner('1, 32'h1_0000, 32'h0, 32'h0, 32'h1_0000, 32'h0);
            send_corner('0, 32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h1_0000);
            // tiny tangent that needs a left shift
            send_corner(24'h1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
            send_corner(24'h2, 32'h1, 32'h0, 32'hffff_ffff, 32'h1, 32'h0);
            send_corner(24'h3, 32'h0, 32'h1, 32'h0, 32'h0, 32'h1);
        end
    endtask

    // zero uv determinant and zero tangent
    task automatic test_degenerate();
        begin
            send_corner(24'h10, 32'h0, 32'h0, 32'h0, 32'h5_0000, 32'h5_0000);
            send_corner(24'h11, 32'h1_0000, 32'h0, 32'h0, 32'h5_0000, 32'h5_0000);
            send_corner(24'h12, 32'h0, 32'h1_0000, 32'h0, 32'h5_0000, 32'h5_0000);
            // collinear uv, det zero
            send_corner(24'h20, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
            send_corner(24'h21, 32'h3, 32'h4, 32'h5, 32'h2_0000, 32'h1_0000);
            send_corner(24'h22, 32'h7, 32'h1, 32'h9, 32'h4_0000, 32'h2_0000);
            // same position, good uv, zero tangent
            send_corner(24'h30, 32'h1234, 32'h5678, 32'h9abc, 32'h0, 32'h0);
            send_corner(24'h31, 32'h1234, 32'h5678, 32'h9abc, 32'h1_0000, 32'h0);
            send_corner(24'h32, 32'h1234, 32'h5678, 32'h9abc, 32'h0, 32'h1_0000);
        end
    endtask

    function automatic logic [COORD_W-1:0] rand_coord();
        begin
            case ($urandom_range(0, 3))
                0:       return $urandom;
                1:       return 32'(signed'($urandom_range(0, 2000)) - 1000);
                2:       return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                                     : 32'h8000_0000 + $urandom_range(0, 3);
                default: return 32'(signed'($urandom_range(0, 32'h40000)) - 32'h20000);
            endcase
        end
    endfunction

    // random corners, mostly full triangles
    task automatic test_random(input int count);
        int n;
        begin
            for (n = 0; n < count; n++)
                send_corner(IDX_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord());
        end
    endtask

    // receiver holds off while corners keep coming
    task automatic test_backpressure();
        begin
            hold_cycles = 600;
            no_gaps = 1'b1;
            test_random(12);
            no_gaps = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        begin
            $display("ERROR result %0d %s got %h expected %h", results_seen, what, got, want);
            error_count++;
        end
    endtask

    // receiver stall pattern, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else if (results_seen % 40 < 15)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 3) != 0);
    end

    // result checker
    always @(posedge clk)
    begin
        tangent_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_tangents.size() == 0)
            begin
                $display("ERROR unexpected result transfer, index %h", m_tdata[IDX_W-1:0]);
                error_count++;
            end
            else
            begin
                want = expected_tangents.pop_front();
                if (m_tdata[23:0] !== want.idx)
                    report_mismatch("out_index", m_tdata[23:0], want.idx);
                if (m_tdata[39:24] !== want.tx)
                    report_mismatch("tangent_x", m_tdata[39:24], want.tx);
                if (m_tdata[55:40] !== want.ty)
                    report_mismatch("tangent_y", m_tdata[55:40], want.ty);
                if (m_tdata[71:56] !== want.tz)
                    report_mismatch("tangent_z", m_tdata[71:56], want.tz);
                if (m_tuser !== want.degen)
                    report_mismatch("degenerate", m_tuser, want.degen);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_triangle", m_tlast, want.last);
                if (want.degen)
                    degenerate_seen++;
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout with %0d results pending", expected_tangents.size());
            $display("FAIL triangle_tangent_vector");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        held_count = 0;
        error_count = 0;
        corners_sent = 0;
        triangles_sent = 0;
        results_seen = 0;
        degenerate_seen = 0;
        idle_cycles = 0;
        hold_cycles = 0;
        burst_left = 0;
        no_gaps = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_degenerate();
        test_backpressure();
        test_random(RANDOM_CORNERS);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_tangents.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d corners, %0d triangles, %0d results (%0d degenerate)",
                 corners_sent, triangles_sent, results_seen, degenerate_seen);
        $display("extremes, zero determinant, zero tangent and a long output stall");
        if (error_count == 0 && expected_tangents.size() == 0)
            $display("PASS triangle_tangent_vector");
        else
            $display("FAIL triangle_tangent_vector");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/ttv_pkg.sv
sv/ttv_front.sv
sv/ttv_fifo.sv
sv/ttv_back.sv
sv/triangle_tangent_vector.sv
tb/triangle_tangent_vector_tb.sv
